// ----- design/pfe_pkg.sv -----
package pfe_pkg;

  localparam int WORD_W = 32;
  localparam int CHAN_W = 8;
  localparam int FMT_W  = 3;

  typedef enum logic [FMT_W-1:0] {
    FMT_R5G6B5   = 3'd0,
    FMT_A4R4G4B4 = 3'd1,
    FMT_R8G8B8   = 3'd2,
    FMT_A8R8G8B8 = 3'd3,
    FMT_A1R5G5B5 = 3'd4
  } pixel_format_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
    logic              has_alpha;
  } pixel_rgba_t;

  // 5-bit to 8-bit rounding expansion
  localparam logic [CHAN_W-1:0] WIDEN5 [32] = '{
    8'd0,   8'd8,   8'd16,  8'd25,  8'd33,  8'd41,  8'd49,  8'd58,
    8'd66,  8'd74,  8'd82,  8'd90,  8'd99,  8'd107, 8'd115, 8'd123,
    8'd132, 8'd140, 8'd148, 8'd156, 8'd165, 8'd173, 8'd181, 8'd189,
    8'd197, 8'd206, 8'd214, 8'd222, 8'd230, 8'd239, 8'd247, 8'd255
  };

  // floor(g * 255 / 63) = 4g + floor(g / 21)
  function automatic logic [CHAN_W-1:0] widen6(input logic [5:0] g);
    logic [1:0] corr;
    corr = (g >= 6'd63) ? 2'd3 : (g >= 6'd42) ? 2'd2 : (g >= 6'd21) ? 2'd1 : 2'd0;
    return {g, 2'b00} + {6'd0, corr};
  endfunction

  // n * 17 replicates the nibble
  function automatic logic [CHAN_W-1:0] widen4(input logic [3:0] n);
    return {n, n};
  endfunction

endpackage

// ----- design/pfe_if.sv -----
interface pfe_in_if;
  logic                        valid;
  logic                        ready;
  logic [pfe_pkg::WORD_W-1:0]  pixel_word;

  modport source (output valid, output pixel_word, input ready);
  modport sink   (input valid, input pixel_word, output ready);
endinterface

interface pfe_out_if;
  logic                        valid;
  logic                        ready;
  logic [pfe_pkg::CHAN_W-1:0]  red;
  logic [pfe_pkg::CHAN_W-1:0]  green;
  logic [pfe_pkg::CHAN_W-1:0]  blue;
  logic [pfe_pkg::CHAN_W-1:0]  alpha;
  logic                        has_alpha;

  modport source (output valid, output red, output green, output blue,
                  output alpha, output has_alpha, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input alpha, input has_alpha, output ready);
endinterface

interface pfe_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [pfe_pkg::FMT_W-1:0]   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/pfe_decode.sv -----
module pfe_decode (
  input  pfe_pkg::pixel_format_t        fmt,
  input  logic [pfe_pkg::WORD_W-1:0]    word,
  output pfe_pkg::pixel_rgba_t          pix
);
  import pfe_pkg::*;

  always_comb begin
    pix = '0;
    case (fmt)
      FMT_R5G6B5: begin
        pix.blue  = WIDEN5[word[4:0]];
        pix.green = widen6(word[10:5]);
        pix.red   = WIDEN5[word[15:11]];
      end
      FMT_A4R4G4B4: begin
        pix.blue      = widen4(word[3:0]);
        pix.green     = widen4(word[7:4]);
        pix.red       = widen4(word[11:8]);
        pix.alpha     = widen4(word[15:12]);
        pix.has_alpha = 1'b1;
      end
      FMT_R8G8B8: begin
        pix.blue  = word[7:0];
        pix.green = word[15:8];
        pix.red   = word[23:16];
      end
      FMT_A8R8G8B8: begin
        pix.blue      = word[7:0];
        pix.green     = word[15:8];
        pix.red       = word[23:16];
        pix.alpha     = word[31:24];
        pix.has_alpha = 1'b1;
      end
      FMT_A1R5G5B5: begin
        pix.blue      = WIDEN5[word[4:0]];
        pix.green     = WIDEN5[word[9:5]];
        pix.red       = WIDEN5[word[14:10]];
        pix.alpha     = {CHAN_W{word[15]}};
        pix.has_alpha = 1'b1;
      end
      default: pix = '0;
    endcase
  end

endmodule

// ----- design/pixel_format_expander.sv -----
// Packed pixel to 8-bit RGBA expander.
// in_ch : one 32-bit packed pixel per beat, byte 0 in bits 7..0.
// out_ch: red, green, blue, alpha and has_alpha, one beat per input beat,
//         in input order.
// cfg_ch: 3-bit pixel format (0 R5G6B5, 1 A4R4G4B4, 2 R8G8B8, 3 A8R8G8B8,
//         4 A1R5G5B5, other codes give all-zero results); always ready,
//         write only while no beats are in flight.
// Two register stages: an input register and a result register with the
// decode between them. A beat goes through the input register, then the
// result register; throughput is one pixel per cycle while out_ch is ready.
// When out_ch stalls, the result register holds and the input register
// still accepts one more beat; ready drops only when both are full.
// Synchronous active-low reset empties both stages and sets format 0.
module pixel_format_expander (
  input  logic              clk,
  input  logic              rst_n,
  pfe_in_if.sink            in_ch,
  pfe_out_if.source         out_ch,
  pfe_cfg_if.sink           cfg_ch
);
  import pfe_pkg::*;

  pixel_format_t     fmt_r;
  logic              s1_valid_r;
  logic [WORD_W-1:0] s1_word_r;
  logic              out_valid_r;
  pixel_rgba_t       out_pix_r;
  pixel_rgba_t       pix_nxt;
  logic              out_adv;
  logic              s1_adv;

  assign out_adv = !out_valid_r || out_ch.ready;
  assign s1_adv  = !s1_valid_r || out_adv;

  assign in_ch.ready  = s1_adv;
  assign cfg_ch.ready = 1'b1;

  pfe_decode u_decode (
    .fmt  (fmt_r),
    .word (s1_word_r),
    .pix  (pix_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r       <= FMT_R5G6B5;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        fmt_r <= pixel_format_t'(cfg_ch.data);
      end
      if (s1_adv) begin
        s1_valid_r <= in_ch.valid;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_ch.valid) begin
      s1_word_r <= in_ch.pixel_word;
    end
    if (out_adv && s1_valid_r) begin
      out_pix_r <= pix_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.red       = out_pix_r.red;
  assign out_ch.green     = out_pix_r.green;
  assign out_ch.blue      = out_pix_r.blue;
  assign out_ch.alpha     = out_pix_r.alpha;
  assign out_ch.has_alpha = out_pix_r.has_alpha;

`ifndef ASSERT_OFF
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !s1_valid_r)
    else $error("pipeline not empty after reset");

  a_alpha_fmt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_pix_r.has_alpha |->
      fmt_r == FMT_A4R4G4B4 || fmt_r == FMT_A8R8G8B8 || fmt_r == FMT_A1R5G5B5)
    else $error("has_alpha set for a three-component format");

  a_no_alpha_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_pix_r.has_alpha |-> out_pix_r.alpha == '0)
    else $error("nonzero alpha without has_alpha");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_ch.ready |=> s1_valid_r && out_valid_r)
    else $error("beat dropped under stall");
`endif

endmodule
